@@ rtl/csa_pkg.sv @@
package csa_pkg;

  localparam int FREQ_BITS  = 8;
  localparam int ACC_BITS   = 32;
  localparam int SCALE_BITS = 32;
  localparam int QUOT_BITS  = 34;
  localparam int SIM_BITS   = 17;

  localparam logic [SIM_BITS-1:0] SIM_ONE = 17'h10000;

endpackage

@@ rtl/csa_accum.sv @@
module csa_accum #(
  parameter int FREQ_BITS = csa_pkg::FREQ_BITS,
  parameter int ACC_BITS  = csa_pkg::ACC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 add_i,
  input  logic                 clear_i,
  input  logic [FREQ_BITS-1:0] freq_a_i,
  input  logic [FREQ_BITS-1:0] freq_b_i,
  output logic [ACC_BITS-1:0]  dot_o,
  output logic [ACC_BITS-1:0]  norm_a_o,
  output logic [ACC_BITS-1:0]  norm_b_o,
  output logic                 sat_o
);

  localparam int PW = 2 * FREQ_BITS;
  localparam int SW = ((ACC_BITS > PW) ? ACC_BITS : PW) + 1;

  function automatic logic [ACC_BITS:0] sat_add(logic [ACC_BITS-1:0] acc, logic [PW-1:0] p);
    logic [SW-1:0] s;
    s = SW'(acc) + SW'(p);
    if (s > SW'({ACC_BITS{1'b1}})) begin
      return {1'b1, {ACC_BITS{1'b1}}};
    end
    return {1'b0, s[ACC_BITS-1:0]};
  endfunction

  logic [ACC_BITS-1:0] dot_q, norm_a_q, norm_b_q;
  logic                sat_q;
  logic [PW-1:0]       prod_ab, prod_aa, prod_bb;
  logic [ACC_BITS:0]   dot_d, norm_a_d, norm_b_d;

  assign prod_ab = PW'(freq_a_i) * PW'(freq_b_i);
  assign prod_aa = PW'(freq_a_i) * PW'(freq_a_i);
  assign prod_bb = PW'(freq_b_i) * PW'(freq_b_i);

  assign dot_d    = sat_add(dot_q, prod_ab);
  assign norm_a_d = sat_add(norm_a_q, prod_aa);
  assign norm_b_d = sat_add(norm_b_q, prod_bb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q    <= '0;
      norm_a_q <= '0;
      norm_b_q <= '0;
      sat_q    <= 1'b0;
    end else if (clear_i) begin
      dot_q    <= '0;
      norm_a_q <= '0;
      norm_b_q <= '0;
      sat_q    <= 1'b0;
    end else if (add_i) begin
      dot_q    <= dot_d[ACC_BITS-1:0];
      norm_a_q <= norm_a_d[ACC_BITS-1:0];
      norm_b_q <= norm_b_d[ACC_BITS-1:0];
      sat_q    <= sat_q | dot_d[ACC_BITS] | norm_a_d[ACC_BITS] | norm_b_d[ACC_BITS];
    end
  end

  assign dot_o    = dot_q;
  assign norm_a_o = norm_a_q;
  assign norm_b_o = norm_b_q;
  assign sat_o    = sat_q;

endmodule

@@ rtl/csa_serial_mul.sv @@
module csa_serial_mul #(
  parameter int W = csa_pkg::ACC_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);

  localparam int CW = $clog2(W);

  logic [W-1:0]   a_q, b_q;
  logic [2*W-1:0] prod_q;
  logic [CW-1:0]  cnt_q;
  logic           run_q, done_q;
  logic [W:0]     sum;

  assign sum = {1'b0, prod_q[2*W-1:W]} + (b_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(W - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      prod_q <= '0;
    end else if (run_q) begin
      b_q    <= {1'b0, b_q[W-1:1]};
      prod_q <= {sum, prod_q[W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

@@ rtl/csa_serial_div.sv @@
module csa_serial_div #(
  parameter int NW = 2 * csa_pkg::ACC_BITS + csa_pkg::SCALE_BITS,
  parameter int DW = 2 * csa_pkg::ACC_BITS,
  parameter int QW = csa_pkg::QUOT_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o,
  output logic          big_o
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q, rem_q;
  logic [QW-1:0] quot_q;
  logic          big_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [DW:0]   sh, diff;
  logic          ge;

  assign sh   = {rem_q, num_q[NW-1]};
  assign diff = sh - {1'b0, den_q};
  assign ge   = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      big_q  <= 1'b0;
    end else if (run_q) begin
      num_q  <= {num_q[NW-2:0], 1'b0};
      rem_q  <= ge ? diff[DW-1:0] : sh[DW-1:0];
      quot_q <= {quot_q[QW-2:0], ge};
      big_q  <= big_q | quot_q[QW-1];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign big_o  = big_q;

endmodule

@@ rtl/csa_serial_sqrt.sv @@
module csa_serial_sqrt #(
  parameter int QW = csa_pkg::QUOT_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [QW-1:0]   rad_i,
  output logic            done_o,
  output logic [QW/2-1:0] root_o
);

  localparam int HW = QW / 2;
  localparam int RW = HW + 1;
  localparam int CW = $clog2(HW);

  logic [QW-1:0] rad_q;
  logic [RW-1:0] rem_q;
  logic [HW-1:0] root_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [RW+1:0] sh, trial, diff;
  logic          ge;

  assign sh    = {rem_q, rad_q[QW-1:QW-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign diff  = sh - trial;
  assign ge    = sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(HW - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[QW-3:0], 2'b00};
      rem_q  <= ge ? diff[RW-1:0] : sh[RW-1:0];
      root_q <= {root_q[HW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ rtl/cosine_similarity_accumulator_top.sv @@
// Cosine similarity of two term-frequency vectors, unsigned Q1.16.
// Input: one pair of frequencies per item on freq_a_i/freq_b_i, taken at a
// rising edge with start high and busy low. last_term_i marks the final pair.
// Items that are not last are absorbed into the dot and norm sums at one per
// cycle; busy stays low between them.
// On a last item busy rises and the result is computed bit-serially: a
// shift-add squaring of the dot sum and product of the norms, a restoring
// divide and a two-bit-per-cycle square root, in that order. done_o strobes
// for one cycle once the root is done; when either norm is zero it strobes
// straight from the check state, with similarity 0 and empty_vector_o set.
// No item is taken while busy is high. sum_overflow_o reports a saturated
// sum during the comparison. Results stay on the ports until the next
// comparison reaches its check state; the receiver cannot stall. Sums clear
// in the check state of each comparison and at reset, which also drops any
// comparison in flight.
module cosine_similarity_accumulator_top #(
  parameter int FREQ_BITS = csa_pkg::FREQ_BITS,
  parameter int ACC_BITS  = csa_pkg::ACC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [FREQ_BITS-1:0]          freq_a_i,
  input  logic [FREQ_BITS-1:0]          freq_b_i,
  input  logic                          last_term_i,
  output logic                          done_o,
  output logic [csa_pkg::SIM_BITS-1:0]  similarity_o,
  output logic                          empty_vector_o,
  output logic                          sum_overflow_o
);

  localparam int PW = 2 * ACC_BITS;
  localparam int NW = PW + csa_pkg::SCALE_BITS;
  localparam int QW = csa_pkg::QUOT_BITS;
  localparam int SB = csa_pkg::SIM_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                done_q, done_d;
  logic [SB-1:0]       sim_q;
  logic                empty_q, ovf_q;
  logic                accept, empty;
  logic                clear, mul_start, div_start, sqrt_start;
  logic [ACC_BITS-1:0] dot, norm_a, norm_b;
  logic                sat;
  logic                mul_dot_done, mul_norm_done, div_done, sqrt_done, big;
  logic [PW-1:0]       dot_sq, norm_prod;
  logic [QW-1:0]       quot;
  logic [QW/2-1:0]     root;
  logic [SB-1:0]       sim_clamped;

  assign accept = start && !busy;
  assign busy   = state_q != ST_IDLE;
  assign empty  = (norm_a == '0) || (norm_b == '0);

  csa_accum #(.FREQ_BITS(FREQ_BITS), .ACC_BITS(ACC_BITS)) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .add_i    (accept),
    .clear_i  (clear),
    .freq_a_i (freq_a_i),
    .freq_b_i (freq_b_i),
    .dot_o    (dot),
    .norm_a_o (norm_a),
    .norm_b_o (norm_b),
    .sat_o    (sat)
  );

  csa_serial_mul #(.W(ACC_BITS)) u_mul_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (dot),
    .b_i     (dot),
    .done_o  (mul_dot_done),
    .prod_o  (dot_sq)
  );

  csa_serial_mul #(.W(ACC_BITS)) u_mul_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (norm_a),
    .b_i     (norm_b),
    .done_o  (mul_norm_done),
    .prod_o  (norm_prod)
  );

  csa_serial_div #(.NW(NW), .DW(PW), .QW(QW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({dot_sq, {csa_pkg::SCALE_BITS{1'b0}}}),
    .den_i   (norm_prod),
    .done_o  (div_done),
    .quot_o  (quot),
    .big_o   (big)
  );

  csa_serial_sqrt #(.QW(QW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (quot),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign sim_clamped = (big || (SB'(root) > csa_pkg::SIM_ONE)) ? csa_pkg::SIM_ONE : SB'(root);

  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    clear      = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && last_term_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        clear = 1'b1;
        if (empty) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_dot_done && mul_norm_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK) begin
      ovf_q   <= sat;
      empty_q <= empty;
      sim_q   <= '0;
    end else if (state_q == ST_SQRT && sqrt_done) begin
      sim_q <= sim_clamped;
    end
  end

  assign done_o         = done_q;
  assign similarity_o   = sim_q;
  assign empty_vector_o = empty_q;
  assign sum_overflow_o = ovf_q;

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_CHECK || state_q == ST_SQRT))
    else $error("result strobe without a comparison in flight");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && empty_vector_o) |-> (similarity_o == '0))
    else $error("empty vector with nonzero similarity");

  a_sim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (similarity_o <= csa_pkg::SIM_ONE))
    else $error("similarity above one");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_term_i) |=> busy)
    else $error("last item did not start a comparison");

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |=> (dot == '0 && norm_a == '0 && norm_b == '0 && !sat))
    else $error("sums not cleared after a comparison");

endmodule
